### rtl/core/slre_pkg.sv
// Shared types and constants for the S/PDIF lock tracker and rate estimator.
package slre_pkg;

	// Command codes carried with each input transaction
	localparam logic [1:0] CMD_LOCK = 2'd0;
	localparam logic [1:0] CMD_LOSS = 2'd1;
	localparam logic [1:0] CMD_TICK = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] REG_UPDATE_INTERVAL = 2'd0;
	localparam logic [1:0] REG_LONG_MIN_SPAN   = 2'd1;
	localparam logic [1:0] REG_HALF_PERIOD     = 2'd2;
	localparam logic [1:0] REG_SMOOTH_SHIFT    = 2'd3;

	// Configuration reset values
	localparam logic [15:0] UPDATE_INTERVAL_RST = 16'd1000;
	localparam logic [31:0] LONG_MIN_SPAN_RST   = 32'd1000000;
	localparam logic [31:0] HALF_PERIOD_RST     = 32'd8000000;
	localparam logic [2:0]  SMOOTH_SHIFT_RST    = 3'd2;

	// Supported nominal rates in Hz
	localparam logic [17:0] RATE_44K1 = 18'd44100;
	localparam logic [17:0] RATE_48K  = 18'd48000;
	localparam logic [17:0] RATE_96K  = 18'd96000;

	localparam logic [7:0] EVENT_MAX = 8'd255;

	// Frames per block times one million: converts a block delta over a span in us to Hz
	localparam int unsigned FRAMES_PER_BLOCK = 192;
	localparam logic [29:0] BLOCK_SCALE      = 30'(FRAMES_PER_BLOCK * 1000000);

	typedef struct packed {
		logic [1:0]  cmd;
		logic [17:0] rate_hz;
		logic [31:0] measured_rate;
		logic [31:0] blk_cnt;
		logic [63:0] time_us;
	} req_t;

	typedef struct packed {
		logic        rate_valid;
		logic [31:0] rate_estimate;
		logic        from_long_window;
		logic        locked;
		logic [7:0]  locks_seen;
		logic [7:0]  losses_seen;
	} rsp_t;

	// Divider handshake between sequencer and divider
	typedef struct packed {
		logic        start;
		logic [63:0] num;
		logic [63:0] den;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] quo;
	} div_rsp_t;

endpackage

### rtl/core/spdif_lock_rate_estimator_top.sv
// Top level: lock tracking, smoothing, anchor rotation and count-based rate sequencing.
//
// Usage:
//   Input transactions (req_valid/req_ready, payload req) carry a command: lock
//   acquired, lock lost or servo tick. Each accepted transaction yields exactly
//   one result transaction (rsp_valid/rsp_ready, payload rsp) holding the new
//   estimate, if any, and the lock status and event counters.
//   Lock, loss and non-updating ticks go from acceptance straight to the finish step.
//   An updating tick runs smoothing, anchor rotation and span check, then, if the
//   span reaches the minimum, a 32x30 multiply and the 64-bit divider, which
//   produces one quotient bit per cycle after an overflow check.
//   One transaction is in work at a time; req_ready is high only while idle.
//   The result sits in an output register; a new transaction may be accepted
//   while it waits, and the next result is held back until rsp_ready takes it.
//   The user writes config (cfg_we, cfg_idx, cfg_wdata) only while idle; not enforced.
//   Reset: unlocked, counters zero, configuration at defaults, no result pending.
module spdif_lock_rate_estimator_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  slre_pkg::req_t      req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output slre_pkg::rsp_t      rsp,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_idx,
	input  logic [31:0]         cfg_wdata
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SMOOTH = 3'd1;
	localparam logic [2:0] S_ROT    = 3'd2;
	localparam logic [2:0] S_SPAN   = 3'd3;
	localparam logic [2:0] S_MUL    = 3'd4;
	localparam logic [2:0] S_START  = 3'd5;
	localparam logic [2:0] S_DIV    = 3'd6;
	localparam logic [2:0] S_FIN    = 3'd7;

	logic [2:0]  state_q;

	logic [15:0] update_interval_q;
	logic [31:0] long_min_span_q;
	logic [31:0] half_period_q;
	logic [2:0]  smooth_shift_q;

	logic        lock_q;
	logic [15:0] skip_q;
	logic [63:0] anchor_t0_q;
	logic [63:0] anchor_t1_q;
	logic [31:0] anchor_b0_q;
	logic [31:0] anchor_b1_q;
	logic        long_valid_q;
	logic [31:0] long_rate_q;
	logic [31:0] smooth_q;
	logic [7:0]  lock_cnt_q;
	logic [7:0]  loss_cnt_q;
	logic        upd_q;

	logic [31:0] meas_q;
	logic [31:0] blocks_q;
	logic [63:0] time_q;
	logic [63:0] span_q;
	logic [31:0] delta_q;
	logic [63:0] prod_q;

	logic        rsp_valid_q;
	slre_pkg::rsp_t rsp_q;

	logic        accept;
	logic        upd_go;
	logic [15:0] skip_next;
	logic [63:0] since_t1;
	logic [63:0] span_w;
	logic [61:0] prod_w;
	logic [31:0] step_up;
	logic [31:0] step_dn;
	logic        out_free;

	slre_pkg::div_req_t div_req;
	slre_pkg::div_rsp_t div_rsp;

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;
	assign skip_next = skip_q + 16'd1;
	assign upd_go    = (req.cmd == slre_pkg::CMD_TICK) && lock_q &&
		(skip_next >= update_interval_q);
	assign since_t1  = time_q - anchor_t1_q;
	assign span_w    = time_q - anchor_t0_q;
	assign prod_w    = delta_q * slre_pkg::BLOCK_SCALE;
	assign step_up   = (meas_q - smooth_q) >> smooth_shift_q;
	assign step_dn   = (smooth_q - meas_q) >> smooth_shift_q;
	assign out_free  = !rsp_valid_q || rsp_ready;

	assign div_req.start = (state_q == S_START);
	assign div_req.num   = prod_q;
	assign div_req.den   = span_q;

	slre_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.div_req (div_req),
		.div_rsp (div_rsp)
	);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			update_interval_q <= slre_pkg::UPDATE_INTERVAL_RST;
			long_min_span_q   <= slre_pkg::LONG_MIN_SPAN_RST;
			half_period_q     <= slre_pkg::HALF_PERIOD_RST;
			smooth_shift_q    <= slre_pkg::SMOOTH_SHIFT_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				slre_pkg::REG_UPDATE_INTERVAL: update_interval_q <= cfg_wdata[15:0];
				slre_pkg::REG_LONG_MIN_SPAN:   long_min_span_q   <= cfg_wdata;
				slre_pkg::REG_HALF_PERIOD:     half_period_q     <= cfg_wdata;
				slre_pkg::REG_SMOOTH_SHIFT:    smooth_shift_q    <= cfg_wdata[2:0];
				default: ;
			endcase
		end
	end

	// Input payload capture
	always_ff @(posedge clk) begin
		if (accept) begin
			meas_q   <= req.measured_rate;
			blocks_q <= req.blk_cnt;
			time_q   <= req.time_us;
		end
		if (state_q == S_SPAN) begin
			span_q  <= span_w;
			delta_q <= blocks_q - anchor_b0_q;
		end
		if (state_q == S_MUL) begin
			prod_q <= {2'b00, prod_w};
		end
	end

	// Sequencer and estimator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			lock_q       <= 1'b0;
			skip_q       <= '0;
			anchor_t0_q  <= '0;
			anchor_t1_q  <= '0;
			anchor_b0_q  <= '0;
			anchor_b1_q  <= '0;
			long_valid_q <= 1'b0;
			long_rate_q  <= '0;
			smooth_q     <= '0;
			lock_cnt_q   <= '0;
			loss_cnt_q   <= '0;
			upd_q        <= 1'b0;
			rsp_valid_q  <= 1'b0;
			rsp_q        <= '0;
		end else begin
			// A result finishing in S_FIN refills the output register itself
			if (rsp_valid_q && rsp_ready && state_q != S_FIN) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						upd_q   <= upd_go;
						state_q <= upd_go ? S_SMOOTH : S_FIN;
						case (req.cmd)
							slre_pkg::CMD_LOCK: begin
								if (lock_cnt_q != slre_pkg::EVENT_MAX) begin
									lock_cnt_q <= lock_cnt_q + 8'd1;
								end
								if (req.rate_hz inside {slre_pkg::RATE_44K1,
										slre_pkg::RATE_48K, slre_pkg::RATE_96K}) begin
									lock_q       <= 1'b1;
									skip_q       <= '0;
									anchor_t0_q  <= req.time_us;
									anchor_t1_q  <= req.time_us;
									anchor_b0_q  <= req.blk_cnt;
									anchor_b1_q  <= req.blk_cnt;
									long_valid_q <= 1'b0;
									long_rate_q  <= '0;
									smooth_q     <= '0;
								end else begin
									lock_q <= 1'b0;
								end
							end
							slre_pkg::CMD_LOSS: begin
								if (loss_cnt_q != slre_pkg::EVENT_MAX) begin
									loss_cnt_q <= loss_cnt_q + 8'd1;
								end
								lock_q <= 1'b0;
								skip_q <= '0;
							end
							slre_pkg::CMD_TICK: begin
								if (lock_q) begin
									skip_q <= upd_go ? '0 : skip_next;
								end
							end
							default: ;
						endcase
					end
				end
				S_SMOOTH: begin
					if (smooth_q == '0) begin
						smooth_q <= meas_q;
					end else if (meas_q >= smooth_q) begin
						smooth_q <= smooth_q + step_up;
					end else begin
						smooth_q <= smooth_q - step_dn;
					end
					state_q <= S_ROT;
				end
				S_ROT: begin
					// Rotate anchors once the newer one is a half period old
					if (since_t1 >= {32'b0, half_period_q}) begin
						anchor_t0_q <= anchor_t1_q;
						anchor_b0_q <= anchor_b1_q;
						anchor_t1_q <= time_q;
						anchor_b1_q <= blocks_q;
					end
					state_q <= S_SPAN;
				end
				S_SPAN: begin
					if (span_w != '0 && span_w >= {32'b0, long_min_span_q}) begin
						state_q <= S_MUL;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_MUL: state_q <= S_START;
				S_START: state_q <= S_DIV;
				S_DIV: begin
					if (div_rsp.done) begin
						long_rate_q  <= div_rsp.quo;
						long_valid_q <= 1'b1;
						state_q      <= S_FIN;
					end
				end
				S_FIN: begin
					// Hold until the output register is free
					if (out_free) begin
						rsp_valid_q            <= 1'b1;
						rsp_q.rate_valid       <= upd_q;
						rsp_q.rate_estimate    <= !upd_q ? '0 :
							(long_valid_q ? long_rate_q : smooth_q);
						rsp_q.from_long_window <= upd_q && long_valid_q;
						rsp_q.locked           <= lock_q;
						rsp_q.locks_seen       <= lock_cnt_q;
						rsp_q.losses_seen      <= loss_cnt_q;
						state_q                <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

### rtl/core/slre_div.sv
// Iterative divider: floor(num * 2^14 / den), saturated to 32 bits, one quotient bit a cycle.
module slre_div (
	input  logic                clk,
	input  logic                arst_n,
	input  slre_pkg::div_req_t  div_req,
	output slre_pkg::div_rsp_t  div_rsp
);

	localparam logic [1:0] D_IDLE = 2'd0;
	localparam logic [1:0] D_CHK  = 2'd1;
	localparam logic [1:0] D_RUN  = 2'd2;

	logic [1:0]  st_q;
	logic [4:0]  cnt_q;
	logic        done_q;
	logic [63:0] num_q;
	logic [63:0] den_q;
	logic [63:0] rem_q;
	logic [31:0] low_q;
	logic [31:0] quo_q;

	logic [64:0] trial;
	logic [65:0] diff;
	logic        ge;
	logic        ovf;

	assign trial = {rem_q, low_q[31]};
	assign diff  = {1'b0, trial} - {2'b00, den_q};
	assign ge    = ~diff[65];
	// Integer part reaching 2^18 saturates the result
	assign ovf   = {18'b0, num_q} >= {den_q, 18'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= D_IDLE;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			case (st_q)
				D_IDLE: begin
					done_q <= 1'b0;
					if (div_req.start) begin
						st_q <= D_CHK;
					end
				end
				D_CHK: begin
					cnt_q  <= '0;
					done_q <= ovf;
					st_q   <= ovf ? D_IDLE : D_RUN;
				end
				D_RUN: begin
					cnt_q  <= cnt_q + 5'd1;
					done_q <= (cnt_q == 5'd31);
					if (cnt_q == 5'd31) begin
						st_q <= D_IDLE;
					end
				end
				default: begin
					done_q <= 1'b0;
					st_q   <= D_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			D_IDLE: begin
				if (div_req.start) begin
					num_q <= div_req.num;
					den_q <= div_req.den;
				end
			end
			D_CHK: begin
				// Top bits of num * 2^14 seed the remainder, the rest shift in
				rem_q <= {18'b0, num_q[63:18]};
				low_q <= {num_q[17:0], 14'b0};
				quo_q <= ovf ? '1 : '0;
			end
			D_RUN: begin
				rem_q <= ge ? diff[63:0] : trial[63:0];
				low_q <= {low_q[30:0], 1'b0};
				quo_q <= {quo_q[30:0], ge};
			end
			default: ;
		endcase
	end

	assign div_rsp.done = done_q;
	assign div_rsp.quo  = quo_q;

endmodule

### rtl/core/slre_checker.sv
// Port-level checker for the lock tracker and rate estimator, bound to the top level.
module slre_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            rsp_valid,
	input logic            rsp_ready,
	input slre_pkg::rsp_t  rsp
);

	logic [7:0] prev_locks_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_locks_q <= '0;
		end else if (rsp_valid && rsp_ready) begin
			prev_locks_q <= rsp.locks_seen;
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result changed or dropped while stalled");

	a_no_est_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.rate_valid |-> rsp.rate_estimate == '0 && !rsp.from_long_window)
		else $error("estimate fields set without a new estimate");

	a_est_locked: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.rate_valid |-> rsp.locked)
		else $error("estimate produced while unlocked");

	a_long_has_est: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.from_long_window |-> rsp.rate_valid)
		else $error("count-based flag without estimate");

	a_locks_mono: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_ready |-> rsp.locks_seen >= prev_locks_q)
		else $error("lock event count went down");

endmodule

bind spdif_lock_rate_estimator_top slre_checker u_slre_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);
